@@ rtl/osa_pkg.sv @@
// Shared types and constants of the int16 operand stack ALU.
package osa_pkg;

    localparam int DEFAULT_STACK_DEPTH = 16;
    localparam int DATA_W  = 16;
    localparam int MODE_W  = 4;
    localparam int STAT_W  = 2;
    localparam int DEPTH_W = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH   = 4'd0,
        MODE_DUP    = 4'd1,
        MODE_OVER   = 4'd2,
        MODE_INVERT = 4'd3,
        MODE_ADD    = 4'd4,
        MODE_SUB    = 4'd5,
        MODE_MUL    = 4'd6,
        MODE_DIV    = 4'd7,
        MODE_MOD    = 4'd8,
        MODE_POP    = 4'd9,
        MODE_POPT   = 4'd10
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } t_status;

endpackage

@@ rtl/osa_in_if.sv @@
// Command channel: operation code and operand.
interface osa_in_if;
    import osa_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, mode, value, input ready);
    modport sink   (input valid, mode, value, output ready);
endinterface

@@ rtl/osa_out_if.sv @@
// Result channel: popped entry, loop flag, status and stack summary.
interface osa_out_if;
    import osa_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] popped_value;
    logic                     popped_valid;
    logic                     loop_back;
    logic [STAT_W-1:0]        status;
    logic [DEPTH_W-1:0]       depth;
    logic signed [DATA_W-1:0] top_value;

    modport source (output valid, popped_value, popped_valid, loop_back, status, depth,
                    top_value, input ready);
    modport sink   (input valid, popped_value, popped_valid, loop_back, status, depth,
                    top_value, output ready);
endinterface

@@ rtl/int16_operand_stack_alu.sv @@
// Stack of signed 16-bit operands driven in reverse Polish order, one result per command.
//
// Operands live in a single-port-write, registered-read memory of STACK_DEPTH
// entries; the top entry is mirrored in a register. A command is read from
// the memory in its accept cycle and enters execution in the next. Push,
// dup, over, invert, add, sub, mul, pop and pop-test finish in execute;
// div and mod pass through execute, 16 steps of the shared radix-2
// restoring divider, and write-back. The result sits in an
// output register; a new command is accepted while it waits, and execution
// holds only if the previous result has not been taken. Arithmetic wraps to
// 16 bits, division truncates toward zero. Underflow, overflow and divide by
// zero are reported in status and leave the stack unchanged. No clearing
// pass: entries above the depth are never read.
module int16_operand_stack_alu #(
    parameter int STACK_DEPTH = osa_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    osa_in_if.sink      i_cmd,
    osa_out_if.source   o_res
);
    import osa_pkg::*;

    localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int DIV_STEPS = DATA_W;
    localparam int DCW = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_DIV  = 4'b0100,
        S_WB   = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [MODE_W-1:0]     r_mode;
    logic [DATA_W-1:0]     r_value;
    logic [CW-1:0]         r_count, n_count;
    logic [DATA_W-1:0]     r_tos, n_tos;
    logic [DATA_W-1:0]     r_rd;
    logic [DATA_W-1:0]     mem [STACK_DEPTH];

    logic                  r_out_valid;
    logic [DATA_W-1:0]     r_popped, n_popped;
    logic                  r_pvalid, n_pvalid;
    logic                  r_loop, n_loop;
    logic [STAT_W-1:0]     r_status, n_status;
    logic [DEPTH_W-1:0]    r_depth;
    logic [DATA_W-1:0]     r_top;

    logic [DATA_W-1:0]     r_quo;
    logic [DATA_W:0]       r_rem;
    logic [DATA_W-1:0]     r_dvs;
    logic [DCW-1:0]        r_dcnt;
    logic                  r_neg_q, r_neg_r;

    logic                  accept, out_free, load_out, go_div;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr, rd_addr;
    logic [DATA_W-1:0]     wr_data;
    logic [CW-1:0]         cnt_m1, cnt_m2;
    logic                  full, lt1, lt2;
    logic [DATA_W-1:0]     opa, opb, arith;
    logic [2*DATA_W-1:0]   prod;
    logic [DATA_W:0]       rem_sh, diff;
    logic [DATA_W-1:0]     div_res, q_fix, r_fix;

    assign accept   = i_cmd.valid && i_cmd.ready;
    assign out_free = !r_out_valid || o_res.ready;
    assign i_cmd.ready = (r_state == S_IDLE);

    assign cnt_m1 = r_count - CW'(1);
    assign cnt_m2 = r_count - CW'(2);
    assign full   = (r_count == CW'(STACK_DEPTH));
    assign lt1    = (r_count == '0);
    assign lt2    = (r_count < CW'(2));
    assign rd_addr = cnt_m2[IW-1:0];

    assign opa  = r_rd;
    assign opb  = r_tos;
    assign prod = opa * opb;

    assign q_fix   = r_neg_q ? (~r_quo + DATA_W'(1)) : r_quo;
    assign r_fix   = r_neg_r ? (~r_rem[DATA_W-1:0] + DATA_W'(1)) : r_rem[DATA_W-1:0];
    assign div_res = (r_mode == MODE_MOD) ? r_fix : q_fix;

    assign rem_sh = {r_rem[DATA_W-1:0], r_quo[DATA_W-1]};
    assign diff   = rem_sh - {1'b0, r_dvs};

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_tos    = r_tos;
        n_popped = '0;
        n_pvalid = 1'b0;
        n_loop   = 1'b0;
        n_status = ST_OK;
        wr_en    = 1'b0;
        wr_addr  = r_count[IW-1:0];
        wr_data  = r_value;
        load_out = 1'b0;
        go_div   = 1'b0;
        arith    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                    unique case (r_mode)
                        MODE_PUSH: begin
                            if (full) begin
                                n_status = ST_OVER;
                            end else begin
                                wr_en   = 1'b1;
                                wr_data = r_value;
                                n_tos   = r_value;
                                n_count = r_count + CW'(1);
                            end
                        end
                        MODE_DUP: begin
                            if (lt1) begin
                                n_status = ST_UNDER;
                            end else if (full) begin
                                n_status = ST_OVER;
                            end else begin
                                wr_en   = 1'b1;
                                wr_data = r_tos;
                                n_count = r_count + CW'(1);
                            end
                        end
                        MODE_OVER: begin
                            if (lt2) begin
                                n_status = ST_UNDER;
                            end else if (full) begin
                                n_status = ST_OVER;
                            end else begin
                                wr_en   = 1'b1;
                                wr_data = opa;
                                n_tos   = opa;
                                n_count = r_count + CW'(1);
                            end
                        end
                        MODE_INVERT: begin
                            if (lt1) begin
                                n_status = ST_UNDER;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = cnt_m1[IW-1:0];
                                wr_data = ~r_tos;
                                n_tos   = ~r_tos;
                            end
                        end
                        MODE_ADD, MODE_SUB, MODE_MUL: begin
                            if (lt2) begin
                                n_status = ST_UNDER;
                            end else begin
                                priority case (r_mode)
                                    MODE_ADD: arith = opa + opb;
                                    MODE_SUB: arith = opa - opb;
                                    default:  arith = prod[DATA_W-1:0];
                                endcase
                                wr_en   = 1'b1;
                                wr_addr = cnt_m2[IW-1:0];
                                wr_data = arith;
                                n_tos   = arith;
                                n_count = cnt_m1;
                            end
                        end
                        MODE_DIV, MODE_MOD: begin
                            if (lt2) begin
                                n_status = ST_UNDER;
                            end else if (opb == '0) begin
                                n_status = ST_DIVZ;
                            end else begin
                                load_out = 1'b0;
                                go_div   = 1'b1;
                                n_state  = S_DIV;
                            end
                        end
                        MODE_POP, MODE_POPT: begin
                            if (lt1) begin
                                n_status = ST_UNDER;
                                n_loop   = (r_mode == MODE_POPT);
                            end else begin
                                n_popped = r_tos;
                                n_pvalid = 1'b1;
                                n_loop   = (r_mode == MODE_POPT) && (r_tos == '0);
                                n_count  = cnt_m1;
                                n_tos    = lt2 ? '0 : opa;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (r_dcnt == DCW'(DIV_STEPS - 1)) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                    wr_en    = 1'b1;
                    wr_addr  = cnt_m2[IW-1:0];
                    wr_data  = div_res;
                    n_tos    = div_res;
                    n_count  = cnt_m1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_cmd.mode;
            r_value <= i_cmd.value;
        end
        r_tos <= n_tos;
        if (load_out) begin
            r_popped <= n_popped;
            r_pvalid <= n_pvalid;
            r_loop   <= n_loop;
            r_status <= n_status;
            r_depth  <= DEPTH_W'(n_count);
            r_top    <= (n_count != '0) ? n_tos : '0;
        end
        if (go_div) begin
            r_quo   <= opa[DATA_W-1] ? (~opa + DATA_W'(1)) : opa;
            r_dvs   <= opb[DATA_W-1] ? (~opb + DATA_W'(1)) : opb;
            r_rem   <= '0;
            r_dcnt  <= '0;
            r_neg_q <= opa[DATA_W-1] ^ opb[DATA_W-1];
            r_neg_r <= opa[DATA_W-1];
        end else if (r_state == S_DIV) begin
            r_dcnt <= r_dcnt + DCW'(1);
            if (!diff[DATA_W]) begin
                r_rem <= diff;
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.popped_value = r_popped;
    assign o_res.popped_valid = r_pvalid;
    assign o_res.loop_back    = r_loop;
    assign o_res.status       = r_status;
    assign o_res.depth        = r_depth;
    assign o_res.top_value    = r_top;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted command not executed next cycle");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && (r_dcnt == DCW'(DIV_STEPS - 1)) |=> (r_state == S_WB))
        else $error("divider did not finish on time");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> ((r_state == S_EXEC) || (r_state == S_WB)) && out_free)
        else $error("memory write outside execute or write-back");

    a_fault_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out && (n_status != ST_OK) |-> !wr_en && (n_count == r_count))
        else $error("faulting command changed the stack");

endmodule

@@ sim/osa_stack_checker.sv @@
// Scoreboard for the operand stack ALU: predicts each result and compares it field by field.
module osa_stack_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    osa_in_if    i_cmd,
    osa_out_if   i_res,
    output int   o_mismatch_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import osa_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0]  popped_value;
        logic                      popped_valid;
        logic                      loop_back;
        logic [STAT_W-1:0]         status;
        logic [DEPTH_W-1:0]        depth;
        logic signed [DATA_W-1:0]  top_value;
    } t_stack_outcome;

    logic signed [DATA_W-1:0] operand_store_model [DEFAULT_STACK_DEPTH];
    int                       stack_level = 0;
    t_stack_outcome           expected_outcomes [$];
    int                       mismatch_count = 0;

    assign o_mismatch_count = mismatch_count;

    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("%0t ns: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    task automatic apply_to_stack_model(input logic [MODE_W-1:0] op,
                                        input logic signed [DATA_W-1:0] operand,
                                        output t_stack_outcome outcome);
        int lhs;
        int rhs;
        int arith;
        outcome = '0;
        outcome.status = ST_OK;
        case (op)
            MODE_PUSH: begin
                if (stack_level >= DEFAULT_STACK_DEPTH) begin
                    outcome.status = ST_OVER;
                end else begin
                    operand_store_model[stack_level] = operand;
                    stack_level++;
                end
            end
            MODE_DUP: begin
                if (stack_level < 1) begin
                    outcome.status = ST_UNDER;
                end else if (stack_level >= DEFAULT_STACK_DEPTH) begin
                    outcome.status = ST_OVER;
                end else begin
                    operand_store_model[stack_level] = operand_store_model[stack_level-1];
                    stack_level++;
                end
            end
            MODE_OVER: begin
                if (stack_level < 2) begin
                    outcome.status = ST_UNDER;
                end else if (stack_level >= DEFAULT_STACK_DEPTH) begin
                    outcome.status = ST_OVER;
                end else begin
                    operand_store_model[stack_level] = operand_store_model[stack_level-2];
                    stack_level++;
                end
            end
            MODE_INVERT: begin
                if (stack_level < 1) begin
                    outcome.status = ST_UNDER;
                end else begin
                    operand_store_model[stack_level-1] = ~operand_store_model[stack_level-1];
                end
            end
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MOD: begin
                if (stack_level < 2) begin
                    outcome.status = ST_UNDER;
                end else begin
                    lhs = int'(operand_store_model[stack_level-2]);
                    rhs = int'(operand_store_model[stack_level-1]);
                    if ((op == MODE_DIV || op == MODE_MOD) && rhs == 0) begin
                        outcome.status = ST_DIVZ;
                    end else begin
                        case (op)
                            MODE_ADD: arith = lhs + rhs;
                            MODE_SUB: arith = lhs - rhs;
                            MODE_MUL: arith = lhs * rhs;
                            MODE_DIV: arith = lhs / rhs;
                            default:  arith = lhs % rhs;
                        endcase
                        operand_store_model[stack_level-2] = arith[DATA_W-1:0];
                        stack_level--;
                    end
                end
            end
            MODE_POP: begin
                if (stack_level < 1) begin
                    outcome.status = ST_UNDER;
                end else begin
                    stack_level--;
                    outcome.popped_value = operand_store_model[stack_level];
                    outcome.popped_valid = 1'b1;
                end
            end
            MODE_POPT: begin
                if (stack_level < 1) begin
                    outcome.status    = ST_UNDER;
                    outcome.loop_back = 1'b1;
                end else begin
                    stack_level--;
                    outcome.popped_value = operand_store_model[stack_level];
                    outcome.popped_valid = 1'b1;
                    outcome.loop_back    = (operand_store_model[stack_level] == '0);
                end
            end
            default: begin
            end
        endcase
        outcome.depth = stack_level[DEPTH_W-1:0];
        if (stack_level > 0) begin
            outcome.top_value = operand_store_model[stack_level-1];
        end
    endtask

    always @(posedge i_clk) begin
        t_stack_outcome want;
        if (!i_rst_n) begin
            stack_level = 0;
            expected_outcomes.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (expected_outcomes.size() == 0) begin
                    report_mismatch("unexpected result, top_value", i_res.top_value, '0);
                end else begin
                    want = expected_outcomes.pop_front();
                    if (i_res.popped_value !== want.popped_value)
                        report_mismatch("popped_value", i_res.popped_value, want.popped_value);
                    if (i_res.popped_valid !== want.popped_valid)
                        report_mismatch("popped_valid", DATA_W'(i_res.popped_valid),
                                        DATA_W'(want.popped_valid));
                    if (i_res.loop_back !== want.loop_back)
                        report_mismatch("loop_back", DATA_W'(i_res.loop_back),
                                        DATA_W'(want.loop_back));
                    if (i_res.status !== want.status)
                        report_mismatch("status", DATA_W'(i_res.status), DATA_W'(want.status));
                    if (i_res.depth !== want.depth)
                        report_mismatch("depth", DATA_W'(i_res.depth), DATA_W'(want.depth));
                    if (i_res.top_value !== want.top_value)
                        report_mismatch("top_value", i_res.top_value, want.top_value);
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                apply_to_stack_model(i_cmd.mode, i_cmd.value, want);
                expected_outcomes.push_back(want);
            end
        end
        o_pending <= expected_outcomes.size();
    end

endmodule

@@ sim/testbench.sv @@
// Top of the operand stack ALU testbench: clock, reset, command stimulus, result stalls, verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import osa_pkg::*;

    localparam int RANDOM_ITEMS    = 1050;
    localparam int IDLE_LIMIT      = 4000;
    localparam int PRESSURE_AFTER  = 500;
    localparam int PRESSURE_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 40;

    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 4'd11;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 4'd15;

    logic i_clk;
    logic i_rst_n;
    int   mismatch_count;
    int   pending_results;
    int   accepted_commands = 0;
    int   idle_cycles = 0;

    osa_in_if  u_cmd_if ();
    osa_out_if u_res_if ();

    int16_operand_stack_alu u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (u_cmd_if),
        .o_res   (u_res_if)
    );

    osa_stack_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (u_cmd_if),
        .i_res            (u_res_if),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (u_cmd_if.valid && u_cmd_if.ready) begin
            accepted_commands <= accepted_commands + 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (u_cmd_if.valid && u_cmd_if.ready) ||
            (u_res_if.valid && u_res_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_command(input logic [MODE_W-1:0] op,
                                input logic signed [DATA_W-1:0] operand);
        @(negedge i_clk);
        u_cmd_if.valid = 1'b1;
        u_cmd_if.mode  = op;
        u_cmd_if.value = operand;
        @(posedge i_clk);
        while (!u_cmd_if.ready) @(posedge i_clk);
    endtask

    task automatic idle_sender(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            u_cmd_if.valid = 1'b0;
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return '0;
            1: begin
                case ($urandom_range(0, 3))
                    0:       return 16'sh8000;
                    1:       return 16'sh7FFF;
                    2:       return -16'sd1;
                    default: return 16'sd1;
                endcase
            end
            2:       return DATA_W'(int'($urandom_range(0, 16)) - 8);
            default: return DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode(input int push_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct) begin
            case ($urandom_range(0, 9))
                0:       return MODE_DUP;
                1:       return MODE_OVER;
                default: return MODE_PUSH;
            endcase
        end
        if ($urandom_range(0, 32) == 0)
            return MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
        return MODE_W'($urandom_range(MODE_INVERT, MODE_POPT));
    endfunction

    initial begin
        int items_sent;
        int burst;
        int push_pct;
        i_rst_n        = 1'b0;
        u_cmd_if.valid = 1'b0;
        u_cmd_if.mode  = MODE_PUSH;
        u_cmd_if.value = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_command(MODE_POP, '0);
        send_command(MODE_POPT, '0);
        send_command(MODE_DUP, '0);
        send_command(MODE_INVERT, '0);
        send_command(MODE_UNUSED_LO, 16'sh7FFF);
        send_command(MODE_PUSH, 16'sh8000);
        send_command(MODE_OVER, '0);
        send_command(MODE_ADD, '0);
        send_command(MODE_PUSH, -16'sd1);
        send_command(MODE_DIV, '0);
        send_command(MODE_PUSH, -16'sd1);
        send_command(MODE_MOD, '0);
        send_command(MODE_PUSH, '0);
        send_command(MODE_DIV, '0);
        send_command(MODE_MOD, '0);
        send_command(MODE_POPT, '0);
        send_command(MODE_PUSH, 16'sh7FFF);
        send_command(MODE_PUSH, 16'sh7FFF);
        send_command(MODE_ADD, '0);
        send_command(MODE_PUSH, -16'sd7);
        send_command(MODE_MUL, '0);
        send_command(MODE_PUSH, 16'sh8000);
        send_command(MODE_SUB, '0);
        send_command(MODE_INVERT, '0);
        send_command(MODE_DUP, '0);
        send_command(MODE_OVER, '0);
        send_command(MODE_POP, '0);
        send_command(MODE_POPT, '0);

        items_sent = 0;
        push_pct   = 50;
        while (items_sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && items_sent < RANDOM_ITEMS; k++) begin
                if (items_sent % 40 == 0) begin
                    case ($urandom_range(0, 2))
                        0:       push_pct = 85;
                        1:       push_pct = 50;
                        default: push_pct = 20;
                    endcase
                end
                send_command(pick_mode(push_pct), pick_operand());
                items_sent++;
            end
            if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 12));
        end
        idle_sender(1);

        while (pending_results != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        int stall_pct;
        bit pressure_done;
        u_res_if.ready = 1'b0;
        pressure_done  = 1'b0;
        @(posedge i_rst_n);
        forever begin
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 20;
                2:       stall_pct = 50;
                default: stall_pct = 80;
            endcase
            repeat ($urandom_range(16, 96)) begin
                @(negedge i_clk);
                if (!pressure_done && accepted_commands >= PRESSURE_AFTER) begin
                    // hold off results so that the command side backs up
                    pressure_done  = 1'b1;
                    u_res_if.ready = 1'b0;
                    repeat (PRESSURE_CYCLES - 1) @(negedge i_clk);
                end else begin
                    u_res_if.ready = ($urandom_range(0, 99) >= stall_pct);
                end
            end
        end
    end

endmodule
